@@ src/kcc_pkg.sv @@
// shared constants, types and helpers for the knob to control change block
package kcc_pkg;

  localparam int NUM_KNOBS    = 8;
  localparam int KNOB_W       = 3;
  localparam int RAW_W        = 10;
  localparam int CC_W         = 7;
  localparam int CHAN_W       = 4;
  localparam int STATUS_W     = 8;
  localparam int TABLE_W      = 56;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int REG_IDX_W    = 2;
  localparam int REG_LSB      = 3;
  localparam int SPAN_W       = CC_W + 1;
  localparam int PROD_W       = 17;
  localparam int RECIP_W      = 18;
  localparam int RECIP_PROD_W = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT  = 27;
  localparam int QUOT_W       = 8;
  localparam int SUM_W        = CC_W + 2;
  localparam int STATE_W      = RAW_W + CC_W;
  localparam int FIFO_DEPTH   = 8;
  localparam int FIFO_IDX_W   = 3;
  localparam int FIFO_CNT_W   = 4;

  localparam logic [RAW_W-1:0]    RAW_CLAMP = 10'd1015;
  localparam logic [RAW_W-1:0]    DEADBAND  = 10'd7;
  localparam logic [STATUS_W-1:0] CC_STATUS = 8'hB0;
  // ceil(2^27 / 1015), exact quotient for every product below 2^17
  localparam logic [RECIP_W-1:0]  RECIP_MUL = 18'd132235;

  localparam logic [REG_IDX_W-1:0] REG_LOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHAN = 2'd3;

  typedef struct packed {
    logic [KNOB_W-1:0] knob;
    logic [RAW_W-1:0]  reading;
    logic [CC_W-1:0]   cc;
    logic [CC_W-1:0]   lo;
    logic [CC_W-1:0]   hi;
    logic              down;
  } item_t;

  typedef struct packed {
    logic [KNOB_W-1:0]   knob;
    logic [STATUS_W-1:0] status;
    logic [CC_W-1:0]     cc;
    logic [CC_W-1:0]     value;
  } event_t;

  function automatic logic [CC_W-1:0] field7(input logic [TABLE_W-1:0] tbl,
                                             input logic [KNOB_W-1:0] k);
    return tbl[CC_W*k +: CC_W];
  endfunction

endpackage

@@ src/knob_to_control_change.sv @@
// knob reading to control change event, with per-knob state memory
// One knob reading is taken every clock. A reading passes four stages (range
// lookup, scale multiply, reciprocal divide by 1015, decide) on its way to
// the output queue. The per-knob state (last sent reading and value) sits in
// a synchronous memory read in the cycle before the decide stage and written
// back there, with a one-deep bypass for the same knob on consecutive
// readings. Events leave through an eight-entry queue; in_ready drops only
// when the queue together with the readings in flight would fill it, so
// with out_ready held high the block sustains one reading per cycle.
// Configuration registers sit at byte addresses 0, 8, 16 and 24; the user
// must write them with the block idle, which the block does not enforce.
module knob_to_control_change (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kcc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [kcc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [kcc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kcc_pkg::KNOB_W-1:0]         in_knob_index,
  input  logic [kcc_pkg::RAW_W-1:0]          in_raw_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [kcc_pkg::KNOB_W-1:0]         out_source_knob,
  output logic [kcc_pkg::STATUS_W-1:0]       out_status_byte,
  output logic [kcc_pkg::CC_W-1:0]           out_controller_number,
  output logic [kcc_pkg::CC_W-1:0]           out_controller_value
);

  // configuration registers
  logic [kcc_pkg::TABLE_W-1:0]   low_table_r;
  logic [kcc_pkg::TABLE_W-1:0]   high_table_r;
  logic [kcc_pkg::TABLE_W-1:0]   ctrl_table_r;
  logic [kcc_pkg::CHAN_W-1:0]    midi_channel_r;
  logic [kcc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[kcc_pkg::REG_LSB +: kcc_pkg::REG_IDX_W];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_table_r    <= '0;
      high_table_r   <= '1;
      ctrl_table_r   <= '0;
      midi_channel_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        kcc_pkg::REG_LOW:  low_table_r    <= pwdata[kcc_pkg::TABLE_W-1:0];
        kcc_pkg::REG_HIGH: high_table_r   <= pwdata[kcc_pkg::TABLE_W-1:0];
        kcc_pkg::REG_CTRL: ctrl_table_r   <= pwdata[kcc_pkg::TABLE_W-1:0];
        kcc_pkg::REG_CHAN: midi_channel_r <= pwdata[kcc_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kcc_pkg::REG_LOW:  prdata = kcc_pkg::CFG_DATA_W'(low_table_r);
      kcc_pkg::REG_HIGH: prdata = kcc_pkg::CFG_DATA_W'(high_table_r);
      kcc_pkg::REG_CTRL: prdata = kcc_pkg::CFG_DATA_W'(ctrl_table_r);
      kcc_pkg::REG_CHAN: prdata = kcc_pkg::CFG_DATA_W'(midi_channel_r);
      default:           prdata = '0;
    endcase
  end

  // stage valids and payloads
  logic                          v1_r, v2_r, v3_r, v4_r;
  kcc_pkg::item_t                s1_r, s2_r, s3_r, s4_r;
  kcc_pkg::item_t                s1_nxt;
  logic [kcc_pkg::SPAN_W-1:0]    span_r, span_nxt;
  logic [kcc_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [kcc_pkg::CC_W-1:0]      value_r, value_nxt;
  logic [kcc_pkg::CC_W-1:0]      dec_value_r;
  logic                          in_fire;
  logic                          knob_ok;

  assign in_fire = in_valid & in_ready;
  assign knob_ok = {1'b0, in_knob_index} < (kcc_pkg::KNOB_W + 1)'(kcc_pkg::NUM_KNOBS);

  // stage 1: clamp, range lookup, span
  always_comb begin
    s1_nxt.knob    = in_knob_index;
    s1_nxt.reading = (in_raw_value > kcc_pkg::RAW_CLAMP) ? kcc_pkg::RAW_CLAMP : in_raw_value;
    s1_nxt.cc      = kcc_pkg::field7(ctrl_table_r, in_knob_index);
    s1_nxt.lo      = kcc_pkg::field7(low_table_r, in_knob_index);
    s1_nxt.hi      = kcc_pkg::field7(high_table_r, in_knob_index);
    s1_nxt.down    = !(s1_nxt.hi > s1_nxt.lo);
    if (s1_nxt.down) begin
      span_nxt = {1'b0, s1_nxt.lo} - {1'b0, s1_nxt.hi} + kcc_pkg::SPAN_W'(1);
    end else begin
      span_nxt = {1'b0, s1_nxt.hi} - {1'b0, s1_nxt.lo} + kcc_pkg::SPAN_W'(1);
    end
  end

  // stage 2: reading times span
  assign prod_nxt = kcc_pkg::PROD_W'(s1_r.reading) * kcc_pkg::PROD_W'(span_r);

  // stage 3: divide by 1015 and place in range
  logic [kcc_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [kcc_pkg::QUOT_W-1:0]       quot;
  logic [kcc_pkg::SUM_W-1:0]        up_sum;
  logic [kcc_pkg::CC_W-1:0]         gap;

  assign recip_prod = kcc_pkg::RECIP_PROD_W'(prod_r) *
                      kcc_pkg::RECIP_PROD_W'(kcc_pkg::RECIP_MUL);
  assign quot       = recip_prod[kcc_pkg::RECIP_SHIFT +: kcc_pkg::QUOT_W];
  assign up_sum     = kcc_pkg::SUM_W'(s2_r.lo) + kcc_pkg::SUM_W'(quot);
  assign gap        = s2_r.lo - s2_r.hi;

  always_comb begin
    if (s2_r.down) begin
      if (quot > {1'b0, gap}) begin
        value_nxt = s2_r.hi;
      end else begin
        value_nxt = s2_r.lo - quot[kcc_pkg::CC_W-1:0];
      end
    end else begin
      if (up_sum > kcc_pkg::SUM_W'(s2_r.hi)) begin
        value_nxt = s2_r.hi;
      end else begin
        value_nxt = up_sum[kcc_pkg::CC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_fire & knob_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r        <= s1_nxt;
    span_r      <= span_nxt;
    s2_r        <= s1_r;
    prod_r      <= prod_nxt;
    s3_r        <= s2_r;
    s4_r        <= s3_r;
    value_r     <= value_nxt;
    dec_value_r <= value_r;
  end

  // per-knob state memory: {sent reading, sent value}
  logic [kcc_pkg::STATE_W-1:0]   state_mem [kcc_pkg::NUM_KNOBS];
  logic [kcc_pkg::STATE_W-1:0]   rd_data_r;
  logic [kcc_pkg::NUM_KNOBS-1:0] sent_once_r;
  logic                          fwd_valid_r;
  logic [kcc_pkg::KNOB_W-1:0]    fwd_knob_r;
  logic [kcc_pkg::STATE_W-1:0]   fwd_data_r;
  logic [kcc_pkg::STATE_W-1:0]   prev_state;
  logic [kcc_pkg::RAW_W-1:0]     prev_raw;
  logic [kcc_pkg::CC_W-1:0]      prev_value;
  logic [kcc_pkg::RAW_W-1:0]     raw_delta;
  logic                          send;
  logic                          push;
  logic [kcc_pkg::STATE_W-1:0]   wr_data;

  always_ff @(posedge clk) begin
    if (v3_r) begin
      rd_data_r <= state_mem[s3_r.knob];
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      state_mem[s4_r.knob] <= wr_data;
    end
  end

  // bypass for a write that lands at the same edge as the memory read
  assign prev_state = (fwd_valid_r && fwd_knob_r == s4_r.knob) ? fwd_data_r : rd_data_r;
  assign prev_raw   = prev_state[kcc_pkg::STATE_W-1 -: kcc_pkg::RAW_W];
  assign prev_value = prev_state[kcc_pkg::CC_W-1:0];
  assign raw_delta  = (s4_r.reading > prev_raw) ? (s4_r.reading - prev_raw)
                                                : (prev_raw - s4_r.reading);
  assign send       = v4_r & (!sent_once_r[s4_r.knob] |
                              ((raw_delta >= kcc_pkg::DEADBAND) && (dec_value_r != prev_value)));
  assign push       = send & (s4_r.cc != '0);
  assign wr_data    = {s4_r.reading, dec_value_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_once_r <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= send;
      if (send) begin
        sent_once_r[s4_r.knob] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_knob_r <= s4_r.knob;
    fwd_data_r <= wr_data;
  end

  // output event queue
  kcc_pkg::event_t                fifo_mem [kcc_pkg::FIFO_DEPTH];
  kcc_pkg::event_t                push_evt;
  logic [kcc_pkg::FIFO_IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [kcc_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [kcc_pkg::FIFO_CNT_W-1:0] committed;
  logic                           pop;

  assign push_evt.knob   = s4_r.knob;
  assign push_evt.status = kcc_pkg::CC_STATUS | kcc_pkg::STATUS_W'(midi_channel_r);
  assign push_evt.cc     = s4_r.cc;
  assign push_evt.value  = dec_value_r;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign cnt_nxt   = cnt_r + kcc_pkg::FIFO_CNT_W'(push) - kcc_pkg::FIFO_CNT_W'(pop);
  assign committed = cnt_r + kcc_pkg::FIFO_CNT_W'(v1_r) + kcc_pkg::FIFO_CNT_W'(v2_r) +
                     kcc_pkg::FIFO_CNT_W'(v3_r) + kcc_pkg::FIFO_CNT_W'(v4_r);
  assign in_ready  = committed < kcc_pkg::FIFO_CNT_W'(kcc_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + kcc_pkg::FIFO_IDX_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + kcc_pkg::FIFO_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_evt;
    end
  end

  assign out_source_knob       = fifo_mem[rd_ptr_r].knob;
  assign out_status_byte       = fifo_mem[rd_ptr_r].status;
  assign out_controller_number = fifo_mem[rd_ptr_r].cc;
  assign out_controller_value  = fifo_mem[rd_ptr_r].value;

endmodule

@@ src/kcc_checker.sv @@
// port-level checks for the knob to control change block, bound to the top level
module kcc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [kcc_pkg::KNOB_W-1:0]         out_source_knob,
  input logic [kcc_pkg::STATUS_W-1:0]       out_status_byte,
  input logic [kcc_pkg::CC_W-1:0]           out_controller_number,
  input logic [kcc_pkg::CC_W-1:0]           out_controller_value
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source_knob) &&
      $stable(out_status_byte) && $stable(out_controller_number) &&
      $stable(out_controller_value))
    else $error("stalled result beat changed");

  // unassigned knobs never produce an event
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_controller_number != '0)
    else $error("event with controller number zero");

  // status byte always carries the control change code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status_byte[kcc_pkg::STATUS_W-1:kcc_pkg::CHAN_W] ==
                  kcc_pkg::CC_STATUS[kcc_pkg::STATUS_W-1:kcc_pkg::CHAN_W])
    else $error("status byte lost the control change code");

  // the event queue is empty out of reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

endmodule

bind knob_to_control_change kcc_checker u_kcc_checker (.*);
